>>> src/b64sd_pkg.sv
package b64sd_pkg;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_62         = 6'd62;
  localparam logic [5:0] SEXTET_63         = 6'd63;

  localparam logic [1:0] LAST_POSITION = 2'd3;
  localparam logic [1:0] PAD_POSITION  = 2'd2;
  localparam logic [1:0] FULL_COUNT    = 2'd3;
  localparam logic [1:0] ONE_COUNT     = 2'd1;

  typedef struct packed {
    logic        valid;
    logic [23:0] triple;
    logic [1:0]  count;
    logic        ends;
    logic        short_group;
  } group_load_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] s;
    s = 6'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      s = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
    end else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_DOT) begin
      s = SEXTET_62;
    end else if (c == CHAR_SLASH || c == CHAR_UNDER || c == CHAR_COMMA) begin
      s = SEXTET_63;
    end
    return s;
  endfunction

endpackage

>>> src/b64sd_char_if.sv
interface b64sd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink (input valid, input char_code, input final_char, output ready);
endinterface

>>> src/b64sd_byte_if.sv
interface b64sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;
  logic       short_group;

  modport source (output valid, output data_byte, output end_of_data, output short_group,
                  input ready);
  modport sink (input valid, input data_byte, input end_of_data, input short_group,
                output ready);
endinterface

>>> src/b64sd_group_decoder.sv
module b64sd_group_decoder (
  input  logic                 clk,
  input  logic                 rst,
  b64sd_char_if.sink           text,
  input  logic                 load_free,
  output b64sd_pkg::group_load_t load
);
  import b64sd_pkg::*;

  logic [17:0] acc;
  logic [17:0] acc_next;
  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic        third_pad;
  logic        third_pad_next;
  logic [5:0]  sextet;
  logic        pad;
  logic        needs_result;
  logic        accept;

  assign sextet       = sextet_of(text.char_code);
  assign pad          = (text.char_code == PAD_CHAR);
  assign needs_result = (pos == LAST_POSITION) || text.final_char;
  assign text.ready   = load_free || !needs_result;
  assign accept       = text.valid && text.ready;

  always_comb begin
    acc_next          = acc;
    pos_next          = pos;
    third_pad_next    = third_pad;
    load.valid        = accept && needs_result;
    load.triple       = {acc, sextet};
    load.count        = FULL_COUNT;
    load.ends         = text.final_char;
    load.short_group  = 1'b0;
    if (pos != LAST_POSITION && text.final_char) begin
      load.triple      = 24'd0;
      load.count       = ONE_COUNT;
      load.short_group = 1'b1;
    end else if (pos == LAST_POSITION && text.final_char) begin
      load.count = FULL_COUNT - {1'b0, pad} - {1'b0, third_pad};
    end
    if (accept) begin
      if (needs_result) begin
        acc_next       = 18'd0;
        pos_next       = 2'd0;
        third_pad_next = 1'b0;
      end else begin
        acc_next = {acc[11:0], sextet};
        pos_next = pos + 2'd1;
        if (pos == PAD_POSITION) begin
          third_pad_next = pad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 18'd0;
      pos       <= 2'd0;
      third_pad <= 1'b0;
    end else begin
      acc       <= acc_next;
      pos       <= pos_next;
      third_pad <= third_pad_next;
    end
  end

  a_group_restart: assert property (@(posedge clk) disable iff (rst)
    load.valid |=> (pos == 2'd0) && (acc == 18'd0) && !third_pad)
    else $error("group state not cleared after result");

  a_pad_only_final: assert property (@(posedge clk) disable iff (rst)
    (load.valid && !load.ends) |-> (load.count == FULL_COUNT))
    else $error("bytes dropped in a group that does not end the string");

endmodule

>>> src/b64sd_byte_serializer.sv
module b64sd_byte_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  b64sd_pkg::group_load_t load,
  output logic                 load_free,
  b64sd_byte_if.source         data
);
  import b64sd_pkg::*;

  logic [23:0] triple;
  logic [1:0]  remaining;
  logic        ends;
  logic        short_flag;

  assign data.valid       = (remaining != 2'd0);
  assign data.data_byte   = triple[23:16];
  assign data.end_of_data = ends && (remaining == ONE_COUNT);
  assign data.short_group = short_flag;
  assign load_free        = (remaining == 2'd0) || ((remaining == ONE_COUNT) && data.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
    end else if (load.valid) begin
      remaining <= load.count;
    end else if (data.valid && data.ready) begin
      remaining <= remaining - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      triple     <= load.triple;
      ends       <= load.ends;
      short_flag <= load.short_group;
    end else if (data.valid && data.ready) begin
      triple <= {triple[15:0], 8'd0};
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load.valid |-> load_free)
    else $error("group loaded over pending bytes");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load.valid |=> data.valid)
    else $error("loaded group not presented");

  a_short_single: assert property (@(posedge clk) disable iff (rst)
    (data.valid && data.short_group) |-> (data.end_of_data && data.data_byte == 8'd0))
    else $error("error result malformed");

endmodule

>>> src/base64_stream_decoder.sv
// Channel  Dir  Fields                                   Word
// text     in   char_code[7:0], final_char               one base64 character
// data     out  data_byte[7:0], end_of_data, short_group one decoded byte
//
// One character is taken per cycle unless it waits as below; each group of four
// yields three bytes (fewer at the end), sent one per cycle while data.ready is high
// from a three-byte output register, the first in the cycle after the fourth char.
// The fourth or final character of a group waits while bytes of the previous group
// are pending, unless the last of them leaves in that same cycle; other characters
// are taken at any time.
// Reset (rst, synchronous) clears the group state and drops pending bytes.
module base64_stream_decoder (
  input  logic         clk,
  input  logic         rst,
  b64sd_char_if.sink   text,
  b64sd_byte_if.source data
);
  import b64sd_pkg::*;

  group_load_t load;
  logic        load_free;

  b64sd_group_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .load_free (load_free),
    .load      (load)
  );

  b64sd_byte_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_free (load_free),
    .data      (data)
  );

endmodule

>>> tb/sv/base64_stream_decoder_check.sv
`timescale 1ns / 100ps

module base64_stream_decoder_check (
  input  logic   clk,
  input  logic   rst,
  b64sd_char_if  text,
  b64sd_byte_if  data,
  output int     error_count,
  output int     pending_count
);
  import b64sd_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
    logic       short_group;
  } byte_word_t;

  byte_word_t  expected_bytes[$];
  logic [17:0] sextet_acc;
  logic [1:0]  group_pos;
  logic        third_pad;

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return 6'(c - CHAR_UPPER_A);
    end
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      return 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
    end
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      return 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
    end
    if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_DOT) begin
      return SEXTET_62;
    end
    if (c == CHAR_SLASH || c == CHAR_UNDER || c == CHAR_COMMA) begin
      return SEXTET_63;
    end
    return 6'd0;
  endfunction

  task automatic clear_group();
    sextet_acc = '0;
    group_pos  = '0;
    third_pad  = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [23:0] triple;
    byte_word_t  w;
    int          n;
    logic        pad;
    pad = (c == PAD_CHAR);
    if (group_pos != LAST_POSITION) begin
      if (fin) begin
        w.data_byte   = 8'h00;
        w.end_of_data = 1'b1;
        w.short_group = 1'b1;
        expected_bytes.push_back(w);
        clear_group();
        return;
      end
      if (group_pos == PAD_POSITION) begin
        third_pad = pad;
      end
      sextet_acc = {sextet_acc[11:0], char_to_sextet(c)};
      group_pos  = group_pos + 2'd1;
    end else begin
      triple = {sextet_acc, char_to_sextet(c)};
      n = 3;
      if (fin) begin
        if (pad) n--;
        if (third_pad) n--;
      end
      for (int k = 0; k < n; k++) begin
        w.data_byte   = triple[23 - 8 * k -: 8];
        w.end_of_data = fin && (k == n - 1);
        w.short_group = 1'b0;
        expected_bytes.push_back(w);
      end
      clear_group();
    end
  endtask

  always @(posedge clk) begin
    byte_word_t want;
    if (rst) begin
      clear_group();
      expected_bytes.delete();
      error_count <= 0;
    end else begin
      if (data.valid && data.ready) begin
        if (expected_bytes.size() == 0) begin
          error_count <= error_count + 1;
          $display("%0t: unexpected word, got byte %h end %b short %b", $time,
                   data.data_byte, data.end_of_data, data.short_group);
        end else begin
          want = expected_bytes.pop_front();
          if (data.data_byte !== want.data_byte || data.end_of_data !== want.end_of_data ||
              data.short_group !== want.short_group) begin
            error_count <= error_count + 1;
            $display("%0t: mismatch, expected byte %h end %b short %b, got byte %h end %b short %b",
                     $time, want.data_byte, want.end_of_data, want.short_group,
                     data.data_byte, data.end_of_data, data.short_group);
          end
        end
      end
      if (text.valid && text.ready) begin
        decode_char(text.char_code, text.final_char);
      end
    end
    pending_count <= expected_bytes.size();
  end

endmodule

>>> tb/sv/base64_stream_decoder_test.sv
`timescale 1ns / 100ps

module base64_stream_decoder_test;
  import b64sd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          idle_on = 1'b1;
  int unsigned chars_sent = 0;
  int          error_count;
  int          pending_count;
  string       alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_.,";

  b64sd_char_if text_ch ();
  b64sd_byte_if byte_ch ();

  base64_stream_decoder u_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .data (byte_ch)
  );

  base64_stream_decoder_check u_chk (
    .clk           (clk),
    .rst           (rst),
    .text          (text_ch),
    .data          (byte_ch),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always #6 clk = ~clk;

  initial begin
    byte_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        byte_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      byte_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  function automatic logic [7:0] alpha_char();
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return PAD_CHAR;
    return alpha_char();
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.char_code  <= c;
    text_ch.final_char <= fin;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], ends && (i == s.len() - 1));
    end
  endtask

  initial begin
    int n_groups;
    int tail;
    int pad_mode;
    text_ch.valid      = 1'b0;
    text_ch.char_code  = 8'h00;
    text_ch.final_char = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("Zz9+-._=", 1'b0);
    send_char(CHAR_SLASH, 1'b0);
    send_char(CHAR_SLASH, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(PAD_CHAR, 1'b1);
    send_text("QU=D", 1'b1);
    send_text("QQ==", 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'h80, 1'b0);
    send_char("B", 1'b1);
    send_text("ABC", 1'b1);

    // hold off until every byte of the directed strings is out
    text_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);

    chars_sent = 0;
    while (chars_sent < 500) begin
      idle_on = (chars_sent < 150 || chars_sent >= 250) && chars_sent < 420;
      n_groups = $urandom_range(0, 3);
      for (int g = 0; g < 4 * n_groups; g++) begin
        send_char(pick_char(), 1'b0);
      end
      if ($urandom_range(0, 4) == 0) begin
        tail = $urandom_range(1, 3);
        for (int k = 0; k < tail; k++) begin
          send_char(pick_char(), k == tail - 1);
        end
      end else begin
        pad_mode = $urandom_range(0, 3);
        send_char(alpha_char(), 1'b0);
        send_char(alpha_char(), 1'b0);
        send_char(pad_mode >= 2 ? PAD_CHAR : pick_char(), 1'b0);
        send_char((pad_mode == 1 || pad_mode == 2) ? PAD_CHAR : pick_char(), 1'b1);
      end
    end

    text_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("base64_stream_decoder_test: done, clean");
    end else begin
      $display("base64_stream_decoder_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("base64_stream_decoder_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
src/b64sd_pkg.sv
src/b64sd_char_if.sv
src/b64sd_byte_if.sv
src/b64sd_group_decoder.sv
src/b64sd_byte_serializer.sv
src/base64_stream_decoder.sv
tb/sv/base64_stream_decoder_check.sv
tb/sv/base64_stream_decoder_test.sv
